FILE: rtl/core/time_sliced_path_interpolator_unit_macros.svh
`ifndef TIME_SLICED_PATH_INTERPOLATOR_UNIT_MACROS_SVH
`define TIME_SLICED_PATH_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define TSPI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tspi check failed");

// next-cycle implication
`define TSPI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tspi check failed");

`endif

FILE: rtl/core/tspi_pkg.sv
package tspi_pkg;

   localparam int unsigned MAX_POINTS = 32;
   localparam int unsigned J_W        = 6;
   localparam int unsigned COORD_W    = 24;
   localparam int unsigned DELTA_W    = 25;
   localparam int unsigned ACC_W      = 50;
   localparam int unsigned ROOT_W     = 25;
   localparam int unsigned REM_W      = 26;
   localparam int unsigned MUL_W      = 26;
   localparam int unsigned PROD_W     = 52;
   localparam int unsigned DIVD_W     = 50;
   localparam int unsigned QUO_W      = 25;
   localparam int unsigned STEP_W     = 21;
   localparam int unsigned T_W        = 26;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FEED_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MS = 2'd1;

   localparam logic [15:0] FEED_RESET   = 16'd600;
   localparam logic [9:0]  PERIOD_RESET = 10'd1;

   // floor(x / 60) as ((x >> 2) * ceil(2^29 / 15)) >> 29, exact for x below 2^27
   localparam logic [MUL_W-1:0] RECIP_15 = 26'd35791395;
   localparam int unsigned      RECIP_SH = 29;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DELTA_W-1:0] delta_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SQ_X,
      MUL_SQ_Y,
      MUL_SQ_Z,
      MUL_FEED,
      MUL_RECIP,
      MUL_CAP,
      MUL_AXIS
   } mul_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_SUM,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_STEP_DIV,
      ST_STEP_WAIT,
      ST_CAP_MUL,
      ST_CAP_SET,
      ST_PT_NEXT,
      ST_PT_CHK,
      ST_AX_MUL,
      ST_AX_DIV,
      ST_AX_WAIT,
      ST_EMIT,
      ST_END_CHK,
      ST_END_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       first;
      logic       commit;
      mul_op_type mul_op;
      logic       acc_load;
      logic       acc_add;
      logic       root_init;
      logic       root_step;
      logic       div_start;
      logic       step_load;
      logic       cap_set;
      logic       pt_next;
      logic       mark_point;
      logic       axis_store;
      logic       mark_end;
   } cmd_type;

   typedef struct packed {
      logic have_prev;
      logic path_end;
      logic root_done;
      logic d_zero;
      logic div_done;
      logic cap_end;
      logic last_pt;
      logic axis_last;
   } status_type;

   function automatic logic [DELTA_W-1:0] abs_delta(input delta_type v);
      abs_delta = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
   endfunction

endpackage

FILE: rtl/core/tspi_div.sv
module tspi_div
   import tspi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [QUO_W-1:0]  divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   // restoring divider, one quotient bit a cycle; dividend < divisor << QUO_W
   logic             run_ff, run_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [QUO_W:0]   trial;
   logic             ge;

   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign ge       = trial >= {1'b0, divisor};
   assign done     = run_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(QUO_W);
         rem_in = dividend[DIVD_W-1:QUO_W];
         quo_in = dividend[QUO_W-1:0];
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            rem_in = ge ? QUO_W'(trial - {1'b0, divisor}) : trial[QUO_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

FILE: rtl/core/tspi_dp.sv
module tspi_dp
   import tspi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COORD_W-1:0]    req_pos_z,
   input  logic                  req_path_end,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [COORD_W-1:0]    rsp_out_x,
   output logic [COORD_W-1:0]    rsp_out_y,
   output logic [COORD_W-1:0]    rsp_out_z,
   output logic                  rsp_run_last,
   output logic                  rsp_capped
);

   logic [15:0]        feed_ff, feed_in;
   logic [9:0]         period_ff, period_in;
   logic               have_prev_ff, have_prev_in;
   coord_type          prev_ff [3];
   coord_type          prev_in [3];
   coord_type          cur_ff [3];
   coord_type          cur_in [3];
   delta_type          dx_ff [3];
   delta_type          dx_in [3];
   coord_type          out_ff [3];
   coord_type          out_in [3];
   logic               end_ff, end_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0]   rcnt_ff, rcnt_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               cap_ff, cap_in;
   logic [T_W-1:0]     t_ff, t_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic [1:0]         axis_ff, axis_in;
   logic               out_last_ff, out_last_in;
   logic               out_cap_ff, out_cap_in;

   coord_type          req_pos [3];
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [ROOT_W-1:0]  t_clip;
   logic [REM_W+1:0]   r_sh, r_trial, r_diff;
   logic               r_ge;
   logic               div_done;
   logic [QUO_W-1:0]   div_q;
   logic [QUO_W:0]     q_signed;
   logic [DELTA_W:0]   lerp_sum;
   logic               last_pt;
   logic               cap_end;
   logic [STEP_W-1:0]  step_q;

   assign req_pos[0] = coord_type'(req_pos_x);
   assign req_pos[1] = coord_type'(req_pos_y);
   assign req_pos[2] = coord_type'(req_pos_z);

   assign t_clip  = (t_ff > {1'b0, root_ff}) ? root_ff : t_ff[ROOT_W-1:0];
   assign last_pt = (j_ff == J_W'(MAX_POINTS)) || (t_ff >= {1'b0, root_ff});
   assign cap_end = cap_ff && (j_ff == J_W'(MAX_POINTS));
   assign step_q  = prod_ff[RECIP_SH +: STEP_W];

   // digit-by-digit square root, two radicand bits a step
   assign r_sh    = {rem_ff, acc_ff[ACC_W-1:ACC_W-2]};
   assign r_trial = {1'b0, root_ff, 2'b01};
   assign r_ge    = r_sh >= r_trial;
   assign r_diff  = r_sh - r_trial;

   tspi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff[DIVD_W-1:0]),
      .divisor  (root_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // truncation toward zero: divide magnitudes, then apply the sign
   assign q_signed = dx_ff[axis_ff][DELTA_W-1] ? -{1'b0, div_q} : {1'b0, div_q};
   assign lerp_sum = {{2{prev_ff[axis_ff][COORD_W-1]}}, prev_ff[axis_ff]} + q_signed;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_SQ_X: begin
            mul_a = MUL_W'(abs_delta(dx_ff[0]));
            mul_b = MUL_W'(abs_delta(dx_ff[0]));
         end
         MUL_SQ_Y: begin
            mul_a = MUL_W'(abs_delta(dx_ff[1]));
            mul_b = MUL_W'(abs_delta(dx_ff[1]));
         end
         MUL_SQ_Z: begin
            mul_a = MUL_W'(abs_delta(dx_ff[2]));
            mul_b = MUL_W'(abs_delta(dx_ff[2]));
         end
         MUL_FEED: begin
            mul_a = MUL_W'(feed_ff);
            mul_b = MUL_W'(period_ff);
         end
         MUL_RECIP: begin
            // feed * period over 60 as a quarter of it times a reciprocal of 15
            mul_a = MUL_W'(prod_ff[26:2]);
            mul_b = RECIP_15;
         end
         MUL_CAP: begin
            mul_a = MUL_W'(step_ff);
            mul_b = MUL_W'(MAX_POINTS);
         end
         MUL_AXIS: begin
            mul_a = MUL_W'(abs_delta(dx_ff[axis_ff]));
            mul_b = MUL_W'(t_clip);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      feed_in      = feed_ff;
      period_in    = period_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      dx_in        = dx_ff;
      out_in       = out_ff;
      end_in       = end_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rcnt_in      = rcnt_ff;
      step_in      = step_ff;
      cap_in       = cap_ff;
      t_in         = t_ff;
      j_in         = j_ff;
      axis_in      = axis_ff;
      out_last_in  = out_last_ff;
      out_cap_in   = out_cap_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_FEED_RATE: feed_in   = csr_wdata;
            CSR_PERIOD_MS: period_in = csr_wdata[9:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         end_in = req_path_end;
         for (int a = 0; a < 3; a++) begin
            cur_in[a] = req_pos[a];
            dx_in[a]  = DELTA_W'(req_pos[a]) - DELTA_W'(prev_ff[a]);
         end
         if (cmd.first) begin
            prev_in      = req_pos;
            have_prev_in = !req_path_end;
         end
      end

      if (cmd.commit) begin
         prev_in      = cur_ff;
         have_prev_in = !end_ff;
      end

      if (cmd.mul_op != MUL_NONE) begin
         prod_in = PROD_W'(mul_a * mul_b);
      end

      if (cmd.acc_load) begin
         acc_in = prod_ff[ACC_W-1:0];
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + prod_ff[ACC_W-1:0];
      end

      if (cmd.root_init) begin
         rem_in  = '0;
         root_in = '0;
         rcnt_in = CNT_W'(ROOT_W);
      end else if (cmd.root_step && (rcnt_ff != '0)) begin
         rem_in  = r_ge ? r_diff[REM_W-1:0] : r_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], r_ge};
         acc_in  = {acc_ff[ACC_W-3:0], 2'b00};
         rcnt_in = rcnt_ff - 1'b1;
      end

      if (cmd.step_load) begin
         step_in = (step_q == '0) ? STEP_W'(1) : step_q;
      end

      if (cmd.cap_set) begin
         cap_in = prod_ff < PROD_W'(root_ff);
         t_in   = '0;
         j_in   = '0;
      end

      if (cmd.pt_next) begin
         t_in    = t_ff + T_W'(step_ff);
         j_in    = j_ff + 1'b1;
         axis_in = '0;
      end

      if (cmd.mark_point) begin
         out_cap_in  = cap_ff;
         out_last_in = last_pt && !end_ff;
         // capped run: the final point snaps to the segment end
         if (cap_end) begin
            out_in = cur_ff;
         end
      end

      if (cmd.axis_store) begin
         out_in[axis_ff] = lerp_sum[COORD_W-1:0];
         axis_in         = axis_ff + 1'b1;
      end

      if (cmd.mark_end) begin
         out_in      = cur_ff;
         out_cap_in  = 1'b0;
         out_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ff      <= FEED_RESET;
         period_ff    <= PERIOD_RESET;
         have_prev_ff <= 1'b0;
         prev_ff      <= '{default: '0};
         rcnt_ff      <= '0;
      end else begin
         feed_ff      <= feed_in;
         period_ff    <= period_in;
         have_prev_ff <= have_prev_in;
         prev_ff      <= prev_in;
         rcnt_ff      <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      dx_ff       <= dx_in;
      out_ff      <= out_in;
      end_ff      <= end_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      cap_ff      <= cap_in;
      t_ff        <= t_in;
      j_ff        <= j_in;
      axis_ff     <= axis_in;
      out_last_ff <= out_last_in;
      out_cap_ff  <= out_cap_in;
   end

   assign status.have_prev = have_prev_ff;
   assign status.path_end  = end_ff;
   assign status.root_done = (rcnt_ff == '0);
   assign status.d_zero    = (root_ff == '0);
   assign status.div_done  = div_done;
   assign status.cap_end   = cap_end;
   assign status.last_pt   = last_pt;
   assign status.axis_last = (axis_ff == 2'd2);

   assign rsp_out_x    = out_ff[0];
   assign rsp_out_y    = out_ff[1];
   assign rsp_out_z    = out_ff[2];
   assign rsp_run_last = out_last_ff;
   assign rsp_capped   = out_cap_ff;

endmodule

FILE: rtl/core/tspi_ctrl.sv
`include "time_sliced_path_interpolator_unit_macros.svh"

module tspi_ctrl
   import tspi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      req_take;
   logic      seg_take;
   logic      axes_done;

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign seg_take  = req_take && status.have_prev;
   assign axes_done = (state_ff == ST_AX_WAIT) && status.div_done && status.axis_last;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT) || (state_ff == ST_END_EMIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (seg_take) state_in = ST_SQ_X;
         ST_SQ_X:      state_in = ST_SQ_Y;
         ST_SQ_Y:      state_in = ST_SQ_Z;
         ST_SQ_Z:      state_in = ST_SQ_SUM;
         ST_SQ_SUM:    state_in = ST_ROOT_INIT;
         ST_ROOT_INIT: state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_done) state_in = status.d_zero ? ST_END_CHK : ST_STEP_DIV;
         end
         ST_STEP_DIV:  state_in = ST_STEP_WAIT;
         ST_STEP_WAIT: state_in = ST_CAP_MUL;
         ST_CAP_MUL:   state_in = ST_CAP_SET;
         ST_CAP_SET:   state_in = ST_PT_NEXT;
         ST_PT_NEXT:   state_in = ST_PT_CHK;
         ST_PT_CHK:    state_in = status.cap_end ? ST_EMIT : ST_AX_MUL;
         ST_AX_MUL:    state_in = ST_AX_DIV;
         ST_AX_DIV:    state_in = ST_AX_WAIT;
         ST_AX_WAIT: begin
            if (status.div_done) state_in = status.axis_last ? ST_EMIT : ST_AX_MUL;
         end
         ST_EMIT: begin
            if (!rsp_stall) state_in = status.last_pt ? ST_END_CHK : ST_PT_NEXT;
         end
         ST_END_CHK:   state_in = status.path_end ? ST_END_EMIT : ST_IDLE;
         ST_END_EMIT:  if (!rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_op = MUL_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.load  = req_take;
            cmd.first = req_take && !status.have_prev;
         end
         ST_SQ_X:      cmd.mul_op = MUL_SQ_X;
         ST_SQ_Y: begin
            cmd.acc_load = 1'b1;
            cmd.mul_op   = MUL_SQ_Y;
         end
         ST_SQ_Z: begin
            cmd.acc_add = 1'b1;
            cmd.mul_op  = MUL_SQ_Z;
         end
         ST_SQ_SUM: begin
            cmd.acc_add = 1'b1;
            cmd.mul_op  = MUL_FEED;
         end
         ST_ROOT_INIT: cmd.root_init = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_STEP_DIV:  cmd.mul_op    = MUL_RECIP;
         ST_STEP_WAIT: cmd.step_load = 1'b1;
         ST_CAP_MUL:   cmd.mul_op    = MUL_CAP;
         ST_CAP_SET:   cmd.cap_set   = 1'b1;
         ST_PT_NEXT:   cmd.pt_next   = 1'b1;
         ST_PT_CHK:    cmd.mark_point = 1'b1;
         ST_AX_MUL:    cmd.mul_op    = MUL_AXIS;
         ST_AX_DIV:    cmd.div_start = 1'b1;
         ST_AX_WAIT:   cmd.axis_store = status.div_done;
         ST_END_CHK: begin
            cmd.mark_end = status.path_end;
            cmd.commit   = !status.path_end;
         end
         ST_END_EMIT:  cmd.commit = !rsp_stall;
         default:      cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `TSPI_ASSERT_NXT(a_segment_starts, clock, reset, seg_take, state_ff == ST_SQ_X)
   `TSPI_ASSERT_IMP(a_no_take_while_out, clock, reset, rsp_valid, req_stall)
   `TSPI_ASSERT_NXT(a_axes_then_emit, clock, reset, axes_done, rsp_valid)

endmodule

FILE: rtl/core/time_sliced_path_interpolator_unit.sv
// Path interpolator: takes one vertex per request transaction and cuts the segment from the
// previous vertex into points one feed step apart, returned as response transactions. A vertex
// is taken only while the block is idle; per segment it first works out the length
// (shared 26x26 multiplier, 25-step square root) and the step (a reciprocal multiply), then
// the points one by one, each axis of each point taking one pass of a serial divider, and it
// waits out any response stall. The first vertex of a path is only stored; a repeated vertex
// ends after the length, with no step and no interpolated points.
module time_sliced_path_interpolator_unit
   import tspi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COORD_W-1:0]    req_pos_z,
   input  logic                  req_path_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_W-1:0]    rsp_out_x,
   output logic [COORD_W-1:0]    rsp_out_y,
   output logic [COORD_W-1:0]    rsp_out_z,
   output logic                  rsp_run_last,
   output logic                  rsp_capped,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tspi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tspi_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .req_path_end (req_path_end),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_run_last (rsp_run_last),
      .rsp_capped   (rsp_capped)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tspi_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned HOLD_CYCLES = 1500;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               run_last;
      logic               capped;
   } path_point_type;

   class path_scoreboard;
      path_point_type pending[$];
      longint feed;
      longint period;
      bit     open_path;
      longint px, py, pz;
      int     mismatches;

      function new();
         feed = FEED_RESET;
         period = PERIOD_RESET;
         open_path = 0;
         px = 0;
         py = 0;
         pz = 0;
         mismatches = 0;
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_FEED_RATE) feed = data;
         else if (idx == CSR_PERIOD_MS) period = data[9:0];
      endfunction

      function longint root_floor(longint v);
         longint lo, hi, mid;
         lo = 0;
         hi = 64'd40000000;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function void push_point(longint x, longint y, longint z, bit cap);
         path_point_type p;
         p.x = x[COORD_W-1:0];
         p.y = y[COORD_W-1:0];
         p.z = z[COORD_W-1:0];
         p.run_last = 0;
         p.capped = cap;
         pending.push_back(p);
      endfunction

      // work out the points one accepted vertex causes
      function void note_vertex(coord_type vx, coord_type vy, coord_type vz, bit last_vertex);
         longint x, y, z, dx, dy, dz, d, stp, n, t;
         int     before_cnt;
         bit     cap;
         x = vx;
         y = vy;
         z = vz;
         before_cnt = pending.size();
         if (open_path) begin
            dx = x - px;
            dy = y - py;
            dz = z - pz;
            d = root_floor(dx * dx + dy * dy + dz * dz);
            if (d != 0) begin
               stp = (feed * period) / 60;
               if (stp < 1) stp = 1;
               n = (d + stp - 1) / stp;
               cap = 0;
               if (n > MAX_POINTS) begin
                  n = MAX_POINTS;
                  cap = 1;
               end
               for (longint j = 1; j <= n; j++) begin
                  if (cap && j == n) push_point(x, y, z, cap);
                  else begin
                     t = j * stp;
                     if (t > d) t = d;
                     push_point(px + (dx * t) / d, py + (dy * t) / d, pz + (dz * t) / d, cap);
                  end
               end
            end
            if (last_vertex) push_point(x, y, z, 0);
         end
         if (pending.size() > before_cnt) pending[pending.size() - 1].run_last = 1;
         px = x;
         py = y;
         pz = z;
         open_path = !last_vertex;
      endfunction

      function void check_point(path_point_type got);
         path_point_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point %h %h %h last=%b cap=%b",
                        got.x, got.y, got.z, got.run_last, got.capped);
            return;
         end
         want = pending.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("point mismatch: expected %h %h %h last=%b cap=%b, got %h %h %h last=%b cap=%b",
                        want.x, want.y, want.z, want.run_last, want.capped,
                        got.x, got.y, got.z, got.run_last, got.capped);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [COORD_W-1:0]    req_pos_x;
   logic [COORD_W-1:0]    req_pos_y;
   logic [COORD_W-1:0]    req_pos_z;
   logic                  req_path_end;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [COORD_W-1:0]    rsp_out_x;
   logic [COORD_W-1:0]    rsp_out_y;
   logic [COORD_W-1:0]    rsp_out_z;
   logic                  rsp_run_last;
   logic                  rsp_capped;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   time_sliced_path_interpolator_unit dut (.*);

   path_scoreboard sb = new();

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit          hold_request;
   int unsigned hold_left;
   int unsigned quiet_cycles;
   longint      cur_x, cur_y, cur_z;
   longint      cur_step;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver: check accepted points, then choose next stall
   always @(posedge clock) begin
      path_point_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_out_x;
         got.y = rsp_out_y;
         got.z = rsp_out_z;
         got.run_last = rsp_run_last;
         got.capped = rsp_capped;
         sb.check_point(got);
      end
      if (hold_request && hold_left == 0) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      if (hold_left > 1 || (hold_request && hold_left == 0)) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.note_config(idx, data);
      @(posedge clock);
   endtask

   task automatic send_vertex(longint x, longint y, longint z, bit last_vertex);
      req_valid <= 1'b1;
      req_pos_x <= x[COORD_W-1:0];
      req_pos_y <= y[COORD_W-1:0];
      req_pos_z <= z[COORD_W-1:0];
      req_path_end <= last_vertex;
      do @(posedge clock); while (req_stall);
      sb.note_vertex(coord_type'(x[COORD_W-1:0]), coord_type'(y[COORD_W-1:0]),
                     coord_type'(z[COORD_W-1:0]), last_vertex);
      cur_x = coord_type'(x[COORD_W-1:0]);
      cur_y = coord_type'(y[COORD_W-1:0]);
      cur_z = coord_type'(z[COORD_W-1:0]);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // let the block drain before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_regs(logic [CSR_DATA_W-1:0] feed, logic [CSR_DATA_W-1:0] per);
      longint s;
      write_reg(CSR_FEED_RATE, feed);
      write_reg(CSR_PERIOD_MS, per);
      s = (longint'(feed) * longint'(per[9:0])) / 60;
      cur_step = (s < 1) ? 1 : s;
   endtask

   function automatic longint near_coord(longint base, longint span);
      return base + longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic longint any_coord();
      return longint'(coord_type'($urandom_range(0, 24'hFFFFFF)));
   endfunction

   task automatic random_paths(int unsigned count);
      int unsigned sent;
      int unsigned left_in_path;
      longint span;
      sent = 0;
      left_in_path = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 8) begin
            // noise: arbitrary vertex with arbitrary end flag
            send_vertex(any_coord(), any_coord(), any_coord(), 1'($urandom_range(1)));
            left_in_path = 0;
         end else if (left_in_path == 0) begin
            send_vertex(any_coord(), any_coord(), any_coord(), 1'b0);
            left_in_path = $urandom_range(1, 5);
         end else begin
            if ($urandom_range(99) < 10) span = 4000000;
            else span = cur_step * $urandom_range(0, 10);
            if (span > 4000000) span = 4000000;
            if ($urandom_range(99) < 5) span = 0;
            left_in_path--;
            send_vertex(near_coord(cur_x, span), near_coord(cur_y, span),
                        near_coord(cur_z, span), left_in_path == 0);
         end
         sent++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_path_end = 1'b0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_FEED_RATE;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      hold_left = 0;
      quiet_cycles = 0;
      cur_x = 0;
      cur_y = 0;
      cur_z = 0;
      cur_step = 10;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings: step of 10 um
      send_vertex(5, 5, 5, 1);                 // lone vertex closing a path
      send_vertex(0, 0, 0, 0);
      send_vertex(100, 0, 0, 0);
      send_vertex(100, 0, 0, 0);               // zero length
      send_vertex(100, 0, 0, 1);               // zero length closing a path
      send_vertex(-8388608, -8388608, -8388608, 0);
      send_vertex(8388607, 8388607, 8388607, 0); // far beyond the point cap
      send_vertex(8388607, -8388608, 0, 1);
      send_vertex(0, 0, 0, 0);
      send_vertex(-37, 23, -5, 0);
      send_vertex(-37, 23, 312, 1);
      send_vertex(1000, 1000, 1000, 0);
      send_vertex(1000, 1000, 1320, 0);        // exactly the point cap
      send_vertex(1000, 1000, 1651, 1);        // two points past it
      drain();

      // out-of-range index must be ignored
      write_reg(CSR_SPARE, 16'hFFFF);
      set_regs(16'd0, 16'd0);                   // step floors to 1
      send_vertex(0, 0, 0, 0);
      send_vertex(3, 4, 0, 0);
      send_vertex(3, 4, 40, 1);
      random_paths(40);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_regs(16'hFFFF, 16'hFFFF);    // largest step, upper data bits masked
            1: set_regs(16'd60000, 16'd1000);
            2: set_regs(16'd1, 16'd1);
            3: set_regs(16'd3000, 16'd10);
            default: set_regs(16'($urandom_range(1, 60000)), 16'($urandom_range(1, 50)));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         if (phase == 3) begin
            // long receiver hold while vertices keep coming
            hold_request = 1;
            wait (hold_left != 0);
            hold_request = 0;
         end
         random_paths(phase == 2 ? 38 : 63);
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
